/* hw/rtl/wildcard_pattern_matcher_unit_defines.svh */
// assertion macros for the wildcard pattern matcher
`ifndef WILDCARD_PATTERN_MATCHER_UNIT_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define WPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpm assertion failed");

// antecedent implies consequent in the next cycle
`define WPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpm assertion failed");

`else

`define WPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define WPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/wpm_pkg.sv */
package wpm_pkg;

  localparam int PATTERN_DEPTH = 128;
  localparam int LEN_W         = $clog2(PATTERN_DEPTH + 1);
  localparam int IDX_W         = $clog2(PATTERN_DEPTH);

  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] QMARK_CHAR = 8'h3F;

  typedef enum logic [1:0] {
    OP_PAT_RESTART,
    OP_PAT_APPEND,
    OP_TEXT,
    OP_TEXT_END
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } res_t;

  // handshake between the front queue and the engine
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_link_t;

endpackage

/* hw/rtl/wpm_front.sv */
module wpm_front
  import wpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  logic      func_i,
  input  logic [7:0] character_i,
  input  logic      last_i,
  output logic      full_o,
  input  logic      cmd_pop_i,
  output cmd_link_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       closed_q, closed_d;
  logic       do_push, do_pop;
  cmd_t       new_cmd;

  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = cmd_pop_i && (cnt_q != 2'd0);

  // classify: pattern restart or append, text byte or end of word
  always_comb begin
    new_cmd.ch = character_i;
    closed_d   = closed_q;
    if (!func_i) begin
      new_cmd.op = closed_q ? OP_PAT_RESTART : OP_PAT_APPEND;
      if (do_push) closed_d = last_i;
    end else begin
      new_cmd.op = last_i ? OP_TEXT_END : OP_TEXT;
    end
  end

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      closed_q <= 1'b1;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      closed_q <= closed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= new_cmd;
  end

  assign cmd_o.valid = (cnt_q != 2'd0);
  assign cmd_o.cmd   = mem_q[rd_ptr_q];

endmodule

/* hw/rtl/wpm_engine.sv */
module wpm_engine
  import wpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_link_t cmd_i,
  output logic      cmd_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output res_t      res_o
);

  logic [7:0]             store_q [PATTERN_DEPTH];
  logic [PATTERN_DEPTH-1:0] star_q, qm_q;
  logic [PATTERN_DEPTH-1:0] en_q, en_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic                   trunc_q, trunc_d;
  logic [PATTERN_DEPTH:0] live_q, live_d;
  logic [PATTERN_DEPTH:0] rst_q, rst_d;

  logic                   fire, is_pat, restart, is_end, wr_en, ch_star;
  logic [LEN_W-1:0]       base_len, len_inc;
  logic [PATTERN_DEPTH-1:0] base_en;
  logic [PATTERN_DEPTH:0] base_rst;
  logic                   base_trunc;
  logic [IDX_W-1:0]       wr_idx;

  logic [PATTERN_DEPTH-1:0] s, lv, hit;
  logic [PATTERN_DEPTH:0] raw, s_ext, gen, carry, nxt;

  always_comb begin
    is_pat  = 1'b0;
    restart = 1'b0;
    is_end  = 1'b0;
    case (cmd_i.cmd.op)
      OP_PAT_RESTART: begin
        is_pat  = 1'b1;
        restart = 1'b1;
      end
      OP_PAT_APPEND: is_pat = 1'b1;
      OP_TEXT:       is_end = 1'b0;
      OP_TEXT_END:   is_end = 1'b1;
      default:       is_pat = 1'b0;
    endcase
  end

  // only an end-of-word beat needs room in the result queue
  assign cmd_pop_o  = cmd_i.valid && (!is_end || !res_full_i);
  assign fire       = cmd_pop_o;
  assign res_push_o = fire && is_end;

  // text step: advance live positions, then close over stars with one add
  always_comb begin
    s  = star_q & en_q;
    lv = live_q[PATTERN_DEPTH-1:0] & en_q;
    for (int p = 0; p < PATTERN_DEPTH; p++) begin
      hit[p] = lv[p] && !s[p] && (qm_q[p] || (store_q[p] == cmd_i.cmd.ch));
    end
    raw   = {1'b0, lv & s} | {hit, 1'b0};
    s_ext = {1'b0, s};
    gen   = raw & s_ext;
    carry = (s_ext + gen) ^ s_ext ^ gen;
    nxt   = raw | carry;
  end

  assign res_o.matched  = nxt[len_q];
  assign res_o.overflow = trunc_q;

  // pattern step: append at the current length or flag overflow when full, keep restart set up to date
  always_comb begin
    base_len   = restart ? '0 : len_q;
    base_en    = restart ? '0 : en_q;
    base_trunc = restart ? 1'b0 : trunc_q;
    base_rst   = restart ? {{PATTERN_DEPTH{1'b0}}, 1'b1} : rst_q;
    wr_en      = base_len < LEN_W'(PATTERN_DEPTH);
    wr_idx     = base_len[IDX_W-1:0];
    len_inc    = base_len + LEN_W'(1);
    ch_star    = (cmd_i.cmd.ch == STAR_CHAR);

    en_d    = base_en;
    rst_d   = base_rst;
    len_d   = base_len;
    trunc_d = base_trunc;
    if (wr_en) begin
      len_d = len_inc;
      for (int p = 0; p < PATTERN_DEPTH; p++) begin
        if (base_len == LEN_W'(p)) en_d[p] = 1'b1;
      end
      if (ch_star) rst_d[len_inc] = base_rst[base_len];
    end else begin
      trunc_d = 1'b1;
    end

    if (is_pat) live_d = rst_d;
    else if (is_end) live_d = rst_q;
    else live_d = nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= '0;
      len_q   <= '0;
      trunc_q <= 1'b0;
      live_q  <= {{PATTERN_DEPTH{1'b0}}, 1'b1};
      rst_q   <= {{PATTERN_DEPTH{1'b0}}, 1'b1};
    end else if (fire) begin
      live_q <= live_d;
      if (is_pat) begin
        en_q    <= en_d;
        len_q   <= len_d;
        trunc_q <= trunc_d;
        rst_q   <= rst_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_pat && wr_en) begin
      store_q[wr_idx] <= cmd_i.cmd.ch;
      star_q[wr_idx]  <= ch_star;
      qm_q[wr_idx]    <= (cmd_i.cmd.ch == QMARK_CHAR);
    end
  end

endmodule

/* hw/rtl/wpm_res_queue.sv */
module wpm_res_queue
  import wpm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= res_i;
  end

  assign res_o = mem_q[rd_ptr_q];

endmodule

/* hw/rtl/wildcard_pattern_matcher_unit.sv */
// Glob matcher for '*' and '?'. Pattern bytes (func 0) are appended one per beat, last closing
// the pattern; the next pattern byte after that starts a new pattern. Text bytes (func 1)
// stream in one per beat and the word's last byte yields one result: matched plus overflow,
// the latter set when pattern bytes beyond wpm_pkg::PATTERN_DEPTH were dropped. One beat is
// accepted every cycle on either kind while full is low; a result reaches the output ports
// through the two-entry command queue, the engine and the two-entry result queue. The cycle
// time is set by the engine's text step: a byte compare at every pattern position followed
// by one PATTERN_DEPTH+1 bit add that closes the live set over runs of stars.
`include "wildcard_pattern_matcher_unit_defines.svh"

module wildcard_pattern_matcher_unit
  import wpm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // input beats
  input  logic       push,
  output logic       full,
  input  logic       func_i,
  input  logic [7:0] character_i,
  input  logic       last_i,
  // result beats
  output logic       empty,
  input  logic       pop,
  output logic       matched_o,
  output logic       overflow_o
);

  cmd_link_t cmd_link;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  res_t      res_in, res_out;

  // front: classifies each beat and buffers it
  wpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .func_i      (func_i),
    .character_i (character_i),
    .last_i      (last_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd_link)
  );

  // back: pattern store and live position set
  wpm_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_link),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // result queue decouples the consumer from the engine
  wpm_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_out)
  );

  assign matched_o  = res_out.matched;
  assign overflow_o = res_out.overflow;

  // the engine never hands a result to a full queue
  `WPM_ASSERT_SAME(a_no_push_when_full, clk_i, rst_ni, res_push, !res_full)
  // an end-of-word beat shows up on the result side the next cycle
  `WPM_ASSERT_NEXT(a_result_visible, clk_i, rst_ni, res_push, !empty)
  // an accepted input beat is queued for the engine the next cycle
  `WPM_ASSERT_NEXT(a_cmd_queued, clk_i, rst_ni, push && !full, cmd_link.valid)

endmodule
